>>> rtl/lfu_cache_lookup_assert.svh
// assertion helpers used by lfu_cache_lookup
`ifndef LFU_CACHE_LOOKUP_ASSERT_SVH
`define LFU_CACHE_LOOKUP_ASSERT_SVH

// condition holds in the same cycle
`define LFUCL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define LFUCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lfucl_pkg.sv
`timescale 1ns / 1ps
package lfucl_pkg;

	// table geometry
	localparam int ENTRIES  = 8;
	localparam int USE_BITS = 16;
	localparam int KEY_W    = 32;
	localparam int CAP_W    = 4;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W    = $clog2(ENTRIES + 1);

	localparam logic [USE_BITS-1:0] USE_MAX = {USE_BITS{1'b1}};

	// register map
	localparam int ADDR_W = 2;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-1:0] REG_CAPACITY_ADDR = 2'd0;
	localparam logic [CAP_W-1:0]  CAPACITY_RESET    = 4'd8;

	typedef logic signed [KEY_W-1:0] key_t;

	// write command to one cell
	typedef struct packed {
		logic insert;
		logic incr;
		key_t key;
		logic value;
	} cell_cmd_t;

	// cell status seen by the controller
	typedef struct packed {
		logic valid;
		logic match;
		logic value;
	} cell_stat_t;

	// eviction candidate passed down the row
	typedef struct packed {
		logic                valid;
		logic [USE_BITS-1:0] uses;
		key_t                key;
		logic [IDX_W-1:0]    idx;
	} cand_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_DONE
	} state_t;

	// signed key order
	function automatic logic key_less(input key_t a, input key_t b);
		return a < b;
	endfunction

endpackage

>>> rtl/lfucl_cell.sv
`timescale 1ns / 1ps
module lfucl_cell import lfucl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  key_t             req_key,
	input  cell_cmd_t        cmd,
	input  cand_t            cand_in,
	output cand_t            cand_out,
	output cell_stat_t       stat
);

	logic                valid_q;
	key_t                key_q;
	logic                value_q;
	logic [USE_BITS-1:0] uses_q;
	cand_t               cand_q;
	logic                take_own;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.insert) begin
			valid_q <= 1'b1;
		end
	end

	// entry payload and saturating use count
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			key_q   <= cmd.key;
			value_q <= cmd.value;
			uses_q  <= USE_BITS'(1);
		end else if (cmd.incr && (uses_q != USE_MAX)) begin
			uses_q <= uses_q + 1'b1;
		end
	end

	// keep the weaker of own entry and the incoming candidate
	always_comb begin
		take_own = valid_q && (!cand_in.valid || (uses_q < cand_in.uses) ||
			((uses_q == cand_in.uses) && key_less(key_q, cand_in.key)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (take_own) begin
			cand_q.valid <= 1'b1;
			cand_q.uses  <= uses_q;
			cand_q.key   <= key_q;
			cand_q.idx   <= idx;
		end else begin
			cand_q <= cand_in;
		end
	end

	assign cand_out    = cand_q;
	assign stat.valid  = valid_q;
	assign stat.match  = valid_q && (key_q == req_key);
	assign stat.value  = value_q;

endmodule

>>> rtl/lfu_cache_lookup.sv
`timescale 1ns / 1ps
// Fully associative cache of signed 32-bit keys with least-frequently-used
// replacement. Each input word carries one key; each result word reports
// hit, the stored or computed value, and the evicted key if any.
// Input channel: in_valid / in_stall / key. Output channel: out_valid /
// out_stall / hit, result_value, evicted, evicted_key. A word moves when
// valid is high and stall is low.
// One request is processed at a time. A hit, or a miss with a free slot,
// goes from the lookup state straight to the done state, where the result
// enters the output register; the next key is taken only once the block is
// back in idle. A miss with a full table first passes through the scan state:
// the eviction candidate walks down the row of cells, one cell per cycle.
// The output register frees the core: a finished result waits there while
// the next key is taken; if out_stall holds the register still full when a
// newer result is ready, the core holds that result and in_stall stays high.
// The capacity register (APB, address 0) sets the number of entries used
// before eviction starts; write it only while the block is idle.
// Reset empties the table, clears both channels and sets capacity to 8.
`include "lfu_cache_lookup_assert.svh"
module lfu_cache_lookup import lfucl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  key_t              key,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic              result_value,
	output logic              evicted,
	output key_t              evicted_key
);

	logic [CAP_W-1:0] capacity_q;
	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] eff_cap;
	logic [IDX_W-1:0] cnt_q;
	state_t           state_q;
	state_t           state_d;
	key_t             req_key_q;

	cell_cmd_t  cmd  [ENTRIES];
	cell_stat_t stat [ENTRIES];
	cand_t      chain[ENTRIES+1];

	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES-1:0] valid_vec;
	logic [ENTRIES-1:0] value_vec;
	logic [ENTRIES-1:0] insert_vec;
	logic [ENTRIES-1:0] incr_vec;
	logic               any_hit;
	logic               hit_value;
	logic               full;
	logic               scan_end;
	logic               miss_value;
	logic [IDX_W-1:0]   free_idx;
	logic               cfg_wr;
	logic               out_load;

	// result held until the output register is free
	logic res_hit_q;
	logic res_value_q;
	logic res_evicted_q;
	key_t res_evkey_q;

	// output register
	logic out_valid_q;
	logic out_hit_q;
	logic out_value_q;
	logic out_evicted_q;
	key_t out_evkey_q;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_CAPACITY_ADDR);
	assign prdata = (paddr == REG_CAPACITY_ADDR) ? DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// clamp capacity to 1..ENTRIES
	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = OCC_W'(1);
		end else if (32'(capacity_q) > 32'(ENTRIES)) begin
			eff_cap = OCC_W'(ENTRIES);
		end else begin
			eff_cap = OCC_W'(capacity_q);
		end
	end

	// request key register
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_key_q <= key;
		end
	end

	// row of cells, candidate chain starts empty
	assign chain[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lfucl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(i)),
			.req_key  (req_key_q),
			.cmd      (cmd[i]),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1]),
			.stat     (stat[i])
		);

		assign match_vec[i] = stat[i].match;
		assign valid_vec[i] = stat[i].valid;
		assign value_vec[i] = stat[i].value;
		assign cmd[i].insert = insert_vec[i];
		assign cmd[i].incr   = incr_vec[i];
		assign cmd[i].key    = req_key_q;
		assign cmd[i].value  = miss_value;
	end

	// lookup summary
	assign any_hit    = |match_vec;
	assign hit_value  = |(match_vec & value_vec);
	assign miss_value = ~req_key_q[0];
	assign full       = (occ_q >= eff_cap);
	assign scan_end   = (cnt_q == IDX_W'(ENTRIES - 1));
	assign out_load   = !out_valid_q || !out_stall;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_vec[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (any_hit || !full) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// cell commands and input stall
	always_comb begin
		insert_vec = '0;
		incr_vec   = '0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_LOOK: begin
				if (any_hit) begin
					incr_vec = match_vec;
				end else if (!full) begin
					for (int i = 0; i < ENTRIES; i++) begin
						insert_vec[i] = (free_idx == IDX_W'(i));
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					for (int i = 0; i < ENTRIES; i++) begin
						insert_vec[i] = (chain[ENTRIES].idx == IDX_W'(i));
					end
				end
			end
			default: begin
				insert_vec = '0;
			end
		endcase
	end

	// state, scan counter and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == ST_SCAN) ? cnt_q + 1'b1 : '0;
			if ((state_q == ST_LOOK) && !any_hit && !full) begin
				occ_q <= occ_q + 1'b1;
			end
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			res_hit_q     <= any_hit;
			res_value_q   <= any_hit ? hit_value : miss_value;
			res_evicted_q <= 1'b0;
			res_evkey_q   <= '0;
		end else if ((state_q == ST_SCAN) && scan_end) begin
			res_evicted_q <= 1'b1;
			res_evkey_q   <= chain[ENTRIES].key;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_load) begin
			out_hit_q     <= res_hit_q;
			out_value_q   <= res_value_q;
			out_evicted_q <= res_evicted_q;
			out_evkey_q   <= res_evkey_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = out_hit_q;
	assign result_value = out_value_q;
	assign evicted      = out_evicted_q;
	assign evicted_key  = out_evkey_q;

	// checks
	`LFUCL_ASSERT_NOW(a_match_unique, state_q == ST_LOOK, $onehot0(match_vec),
		"lfu_cache_lookup: key stored in more than one cell")
	`LFUCL_ASSERT_NOW(a_occ_count, 1'b1, 32'(occ_q) == 32'($countones(valid_vec)),
		"lfu_cache_lookup: occupancy differs from valid entries")
	`LFUCL_ASSERT_NOW(a_hit_no_evict, out_valid && hit, !evicted,
		"lfu_cache_lookup: eviction reported on a hit")
	`LFUCL_ASSERT_NEXT(a_accept_look, in_valid && !in_stall, state_q == ST_LOOK,
		"lfu_cache_lookup: accepted word not looked up")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top import lfucl_pkg::*; ();

	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 12;
	localparam int PHASE_WORDS = 130;
	localparam int POOL_SIZE   = 12;

	// one result word as the block reports it
	typedef struct packed {
		logic hit;
		logic value;
		logic evicted;
		key_t evicted_key;
	} lookup_word_t;

	// software copy of the cache table and the results it owes
	class lfu_mirror;
		bit                  live [ENTRIES];
		key_t                keys [ENTRIES];
		bit                  vals [ENTRIES];
		logic [USE_BITS-1:0] uses [ENTRIES];
		int                  fill;
		logic [CAP_W-1:0]    cap;
		lookup_word_t        due[$];
		int                  bad;
		int                  lookups;
		int                  hits;
		int                  evictions;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				live[i] = 1'b0;
				keys[i] = '0;
				vals[i] = 1'b0;
				uses[i] = '0;
			end
			fill = 0;
			cap = CAPACITY_RESET;
			bad = 0;
			lookups = 0;
			hits = 0;
			evictions = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			cap = c;
		endfunction

		// zero acts as one, anything above the table size as the table size
		function int usable_slots();
			if (cap == 0)
				return 1;
			if (int'(cap) > ENTRIES)
				return ENTRIES;
			return int'(cap);
		endfunction

		// predict the result of one accepted key and update the table
		function void take_key(key_t k);
			int slot;
			int victim;
			lookup_word_t w;
			slot = -1;
			victim = -1;
			w = '0;
			lookups++;
			for (int i = 0; i < ENTRIES; i++)
				if (slot < 0 && live[i] && keys[i] == k)
					slot = i;
			if (slot >= 0) begin
				w.hit = 1'b1;
				w.value = vals[slot];
				if (uses[slot] != USE_MAX)
					uses[slot] = uses[slot] + 1'b1;
				hits++;
			end else begin
				w.value = ~k[0];
				if (fill >= usable_slots()) begin
					// lowest count loses, ties go to the smaller signed key
					for (int i = 0; i < ENTRIES; i++)
						if (live[i] && (victim < 0 || uses[i] < uses[victim] ||
							(uses[i] == uses[victim] && keys[i] < keys[victim])))
							victim = i;
					if (victim >= 0) begin
						w.evicted = 1'b1;
						w.evicted_key = keys[victim];
						live[victim] = 1'b0;
						fill--;
						slot = victim;
						evictions++;
					end
				end
				if (slot < 0)
					for (int i = ENTRIES - 1; i >= 0; i--)
						if (!live[i])
							slot = i;
				if (slot >= 0) begin
					live[slot] = 1'b1;
					keys[slot] = k;
					vals[slot] = w.value;
					uses[slot] = USE_BITS'(1);
					fill++;
				end
			end
			due.push_back(w);
		endfunction

		// compare one result word with the oldest prediction
		function void check_word(lookup_word_t got);
			lookup_word_t want;
			if (due.size() == 0) begin
				bad++;
				if (bad <= 10)
					$display("[%0t] unexpected result: hit=%0b val=%0b ev=%0b evkey=%0d",
						$realtime, got.hit, got.value, got.evicted, got.evicted_key);
				return;
			end
			want = due.pop_front();
			if (got.hit !== want.hit || got.value !== want.value ||
				got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
				bad++;
				// fields in order hit/value/evicted/evicted_key
				if (bad <= 10)
					$display("[%0t] mismatch: want %0b/%0b/%0b/%0d, got %0b/%0b/%0b/%0d",
						$realtime, want.hit, want.value, want.evicted, want.evicted_key,
						got.hit, got.value, got.evicted, got.evicted_key);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	key_t              key = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              hit;
	logic              result_value;
	logic              evicted;
	key_t              evicted_key;

	lfu_mirror mirror;
	bit        tx_idle_on = 1'b0;
	bit        rx_idle_on = 1'b0;
	bit        hold_request = 1'b0;
	int        stuck_cycles = 0;
	int        cap_writes = 0;
	key_t      hot_keys [POOL_SIZE];
	key_t      last_key = '0;

	// extremes, both value parities, hits, ties on the count and eviction order
	key_t opening_keys [17] = '{
		32'sd0, 32'sd1, 32'sh7fffffff, 32'sh80000000, -32'sd1, -32'sd2,
		32'sd0, 32'sh80000000, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd4,
		-32'sd1, 32'sd1, 32'sh7fffffff, -32'sd3
	};
	key_t corner_keys [6] = '{
		32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1, 32'sd1, 32'sh80000001
	};
	logic [CAP_W-1:0] phase_caps [PHASES] = '{
		4'd1, 4'd0, 4'd15, 4'd8, 4'd3, 4'd2, 4'd9, 4'd5, 4'd4, 4'd7, 4'd6, 4'd8
	};

	lfu_cache_lookup u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.key         (key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.result_value(result_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watch both channels at each edge
	always @(posedge clk) begin : port_watch
		lookup_word_t seen;
		if (arst_n) begin
			if (in_valid && !in_stall)
				mirror.take_key(key);
			if (out_valid && !out_stall) begin
				seen.hit = hit;
				seen.value = result_value;
				seen.evicted = evicted;
				seen.evicted_key = evicted_key;
				mirror.check_word(seen);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
	end

	// result side: random stall bursts plus one long hold-off on request
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 12);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// offer one key word and hold it until taken
	task automatic send_key(input key_t k);
		if (tx_idle_on && $urandom_range(0, 6) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		key <= k;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (mirror.due.size() != 0)
			@(posedge clk);
	endtask

	// apb write of the capacity register while the block is idle
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		logic [DATA_W-1:0] wd;
		wd = $urandom;
		wd[CAP_W-1:0] = c;
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_CAPACITY_ADDR;
		pwdata <= wd;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mirror.set_capacity(c);
		cap_writes++;
	endtask

	// working set for one phase: some wide random keys, some near zero
	task automatic refresh_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			if ($urandom_range(0, 1) == 1)
				hot_keys[i] = key_t'($urandom);
			else
				hot_keys[i] = key_t'(int'($urandom_range(0, 40)) - 20);
	endtask

	// mostly reuse of the working set so hits and count ties are common
	function automatic key_t pick_key();
		int r;
		key_t k;
		r = $urandom_range(0, 99);
		if (r < 55)
			k = hot_keys[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 70)
			k = last_key;
		else if (r < 80)
			k = corner_keys[$urandom_range(0, 5)];
		else
			k = key_t'($urandom);
		last_key = k;
		return k;
	endfunction

	initial begin : timeout_guard
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		mirror = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening at the reset capacity
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		foreach (opening_keys[i])
			send_key(opening_keys[i]);

		// build up one entry's use count, then raise the others
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int n = 0; n < 20; n++)
			send_key(32'sd0);
		wait_drained();
		for (int i = 0; i < ENTRIES; i++)
			if (mirror.live[i] && mirror.keys[i] != 32'sd0)
				for (int n = 0; n < 12; n++)
					send_key(mirror.keys[i]);
		for (int n = 0; n < 12; n++)
			send_key(key_t'($urandom));
		send_key(32'sd0);

		// random phases over a sweep of capacity settings
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(phase_caps[ph]);
			refresh_pool();
			tx_idle_on = !(ph == 2 || ph == PHASES - 1);
			rx_idle_on = (ph != PHASES - 1);
			if (ph == 2)
				hold_request = 1'b1;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (ph == 5 && n == PHASE_WORDS / 2)
					wait_drained();
				send_key(pick_key());
			end
		end

		wait_drained();
		repeat (ENTRIES + 6) @(posedge clk);
		$display("checked %0d lookups: %0d hits, %0d evictions, %0d capacity writes",
			mirror.lookups, mirror.hits, mirror.evictions, cap_writes);
		$display("covered count ties, capacity 0 and 15, and shrinking below occupancy");
		if (mirror.bad == 0 && mirror.due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
